// File: design/ufx_pkg.sv
// Shared types and constants for the URL form field extractor.
`default_nettype none
package ufx_pkg;

    localparam int TAG_MAX_CHARS = 8;
    localparam int TAG_BITS      = 8 * TAG_MAX_CHARS;
    localparam int TAG_IDX_W     = (TAG_MAX_CHARS > 1) ? $clog2(TAG_MAX_CHARS) : 1;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TAG_CHARS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN    = 2'd2;

    localparam logic [63:0] TAG_CHARS_RST = 64'd0;
    localparam logic [3:0]  TAG_LEN_RST   = 4'd1;
    localparam logic [15:0] MAX_LEN_RST   = 16'd1024;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    // one result word
    typedef struct packed {
        logic [7:0] value;
        logic       is_done;
        logic       found;
        logic       last;
    } item_t;

    // all result words caused by one input word
    typedef struct packed {
        logic [2:0]      cnt;
        item_t [3:0]     items;
    } bundle_t;

    typedef struct packed {
        logic    valid;
        bundle_t data;
    } q_push_t;

    typedef struct packed {
        logic    full;
        logic    empty;
        bundle_t head;
    } q_status_t;

endpackage
`default_nettype wire

// File: design/ufx_front.sv
// Front end: tag search, separator skip and percent decoding, one input word per cycle while the queue is not full.
`default_nettype none
module ufx_front
    import ufx_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  end_of_buffer,
    input  wire logic                  q_full,
    output logic                       in_accept,
    output q_push_t                    push,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        PH_SEARCH  = 3'd0,
        PH_SEP     = 3'd1,
        PH_FIRST   = 3'd2,
        PH_VALUE   = 3'd3,
        PH_STOPPED = 3'd4
    } phase_t;

    typedef struct packed {
        phase_t          ph;
        logic [1:0]      esc;
        logic [7:0]      held;
        logic [15:0]     ecnt;
        logic [1:0]      nval;
        logic [2:0][7:0] vals;
    } work_t;

    logic [63:0]         tag_chars_reg;
    logic [3:0]          tag_len_reg;
    logic [15:0]         max_len_reg;

    phase_t              phase_reg, phase_next;
    logic [TAG_BITS-1:0] win_reg, win_next;
    logic [3:0]          seen_reg, seen_next;
    logic [1:0]          esc_reg, esc_next;
    logic [7:0]          held_reg, held_next;
    logic [15:0]         ecnt_reg, ecnt_next;
    logic                fnd_reg, fnd_next;

    work_t               w;
    logic [3:0]          len;
    logic [1:0]          p;
    bundle_t             bnd;

    function automatic logic [7:0] to_lower(logic [7:0] b);
        return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    endfunction

    function automatic logic [4:0] hex_value(logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= "0" && b <= "9") r = {1'b1, 4'(b - "0")};
        else if (b >= "A" && b <= "F") r = {1'b1, 4'(b - "A" + 8'd10)};
        else if (b >= "a" && b <= "f") r = {1'b1, 4'(b - "a" + 8'd10)};
        return r;
    endfunction

    function automatic logic window_match(logic [TAG_BITS-1:0] win, logic [63:0] tag,
                                          logic [3:0] n);
        logic                 ok;
        logic [TAG_IDX_W-1:0] k;
        ok = 1'b1;
        for (int i = 0; i < TAG_MAX_CHARS; i++) begin
            if (4'(i) < n) begin
                k = TAG_IDX_W'(n - 4'd1 - 4'(i));
                if (to_lower(tag[8*i +: 8]) != win[8*k +: 8]) ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic work_t emit_value(work_t s, logic [7:0] v, logic [15:0] lim);
        work_t r;
        r = s;
        if (s.ph == PH_VALUE) begin
            if (s.ecnt >= lim) begin
                r.ph  = PH_STOPPED;
                r.esc = 2'd0;
            end
            else if (s.nval != 2'd3) begin
                r.vals[s.nval] = v;
                r.nval         = s.nval + 2'd1;
                r.ecnt         = s.ecnt + 16'd1;
            end
        end
        return r;
    endfunction

    function automatic work_t plain_byte(work_t s, logic [7:0] b, logic [15:0] lim);
        work_t r;
        r = s;
        if (s.ph == PH_VALUE) begin
            if (b == 8'h00 || b == "&") begin
                r.ph  = PH_STOPPED;
                r.esc = 2'd0;
            end
            else if (b == 8'h0D || b == 8'h0A || b == 8'h09) begin
                r = s;
            end
            else if (b == "+") r = emit_value(s, " ", lim);
            else if (b == "%") r.esc = 2'd1;
            else r = emit_value(s, b, lim);
        end
        return r;
    endfunction

    function automatic work_t value_byte(work_t s, logic [7:0] b, logic [15:0] lim);
        work_t      r;
        logic [4:0] h;
        logic [4:0] hi;
        r  = s;
        h  = hex_value(b);
        hi = hex_value(s.held);
        if (s.esc == 2'd1) begin
            if (h[4]) begin
                r.held = b;
                r.esc  = 2'd2;
            end
            else begin
                r.esc = 2'd0;
                r     = emit_value(r, "%", lim);
                r     = plain_byte(r, b, lim);
            end
        end
        else if (s.esc == 2'd2) begin
            r.esc = 2'd0;
            if (h[4]) begin
                r = emit_value(r, {hi[3:0], h[3:0]}, lim);
            end
            else begin
                r = emit_value(r, "%", lim);
                r = emit_value(r, s.held, lim);
                r = plain_byte(r, b, lim);
            end
        end
        else begin
            r = plain_byte(s, b, lim);
        end
        return r;
    endfunction

    assign in_accept = in_valid && !q_full;
    assign len = (tag_len_reg > 4'(TAG_MAX_CHARS)) ? 4'(TAG_MAX_CHARS) : tag_len_reg;

    always_comb
    begin
        w.ph   = phase_reg;
        w.esc  = esc_reg;
        w.held = held_reg;
        w.ecnt = ecnt_reg;
        w.nval = 2'd0;
        w.vals = '0;
        win_next  = win_reg;
        seen_next = seen_reg;
        fnd_next  = fnd_reg;
        p         = 2'd0;

        case (phase_reg)
            PH_SEARCH:
            begin
                if (data_byte == 8'h00) w.ph = PH_STOPPED;
                else if (len == 4'd0) w.ph = PH_FIRST;
                else
                begin
                    win_next = {win_reg[TAG_BITS-9:0], to_lower(data_byte)};
                    if (seen_reg != 4'hF) seen_next = seen_reg + 4'd1;
                    if (seen_next >= len && window_match(win_next, tag_chars_reg, len))
                        w.ph = PH_SEP;
                end
            end
            PH_SEP:
            begin
                w.ph = (data_byte == 8'h00) ? PH_STOPPED : PH_FIRST;
            end
            PH_FIRST:
            begin
                if (data_byte == 8'h00) w.ph = PH_STOPPED;
                else
                begin
                    fnd_next = 1'b1;
                    w.ph     = PH_VALUE;
                    w        = value_byte(w, data_byte, max_len_reg);
                end
            end
            PH_VALUE:
            begin
                w = value_byte(w, data_byte, max_len_reg);
            end
            default:
            begin
                w.ph = phase_reg;
            end
        endcase

        // flush a held escape at buffer end
        if (end_of_buffer && w.ph == PH_VALUE)
        begin
            p     = w.esc;
            w.esc = 2'd0;
            if (p != 2'd0) w = emit_value(w, "%", max_len_reg);
            if (p == 2'd2) w = emit_value(w, w.held, max_len_reg);
        end

        bnd = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (2'(i) < w.nval) bnd.items[i].value = w.vals[i];
        end
        if (end_of_buffer)
        begin
            bnd.items[w.nval].is_done = 1'b1;
            bnd.items[w.nval].found   = fnd_next;
        end
        bnd.cnt = {1'b0, w.nval} + {2'b00, end_of_buffer};
        if (bnd.cnt != 3'd0) bnd.items[2'(bnd.cnt - 3'd1)].last = 1'b1;

        push.valid = in_accept && (bnd.cnt != 3'd0);
        push.data  = bnd;

        phase_next = w.ph;
        esc_next   = w.esc;
        held_next  = w.held;
        ecnt_next  = w.ecnt;
        if (end_of_buffer)
        begin
            phase_next = PH_SEARCH;
            win_next   = '0;
            seen_next  = 4'd0;
            esc_next   = 2'd0;
            held_next  = 8'd0;
            ecnt_next  = 16'd0;
            fnd_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_chars_reg <= TAG_CHARS_RST;
            tag_len_reg   <= TAG_LEN_RST;
            max_len_reg   <= MAX_LEN_RST;
            phase_reg     <= PH_SEARCH;
            win_reg       <= '0;
            seen_reg      <= 4'd0;
            esc_reg       <= 2'd0;
            held_reg      <= 8'd0;
            ecnt_reg      <= 16'd0;
            fnd_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TAG_CHARS:  tag_chars_reg <= cfg_data[63:0];
                    CFG_TAG_LENGTH: tag_len_reg   <= cfg_data[3:0];
                    CFG_MAX_LEN:    max_len_reg   <= cfg_data[15:0];
                    default:        tag_len_reg   <= tag_len_reg;
                endcase
            end
            if (in_accept)
            begin
                phase_reg <= phase_next;
                win_reg   <= win_next;
                seen_reg  <= seen_next;
                esc_reg   <= esc_next;
                held_reg  <= held_next;
                ecnt_reg  <= ecnt_next;
                fnd_reg   <= fnd_next;
            end
        end
    end

endmodule
`default_nettype wire

// File: design/ufx_queue.sv
// Short queue of result bundles between the front and back ends.
`default_nettype none
module ufx_queue
    import ufx_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire q_push_t   push,
    input  wire logic      pop,
    output q_status_t      status
);

    bundle_t               mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]    wr_ptr_reg;
    logic [Q_PTR_W-1:0]    rd_ptr_reg;
    logic [Q_PTR_W:0]      count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign status.full  = (count_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign status.empty = (count_reg == '0);
    assign status.head  = mem[rd_ptr_reg];
    assign do_push = push.valid && !status.full;
    assign do_pop  = pop && !status.empty;

    always_ff @(posedge clk)
    begin
        if (do_push) mem[wr_ptr_reg] <= push.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop) rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop) count_reg <= count_reg + 1'b1;
            else if (!do_push && do_pop) count_reg <= count_reg - 1'b1;
        end
    end

endmodule
`default_nettype wire

// File: design/ufx_back.sv
// Back end: unpacks bundles into single result words behind an output register.
`default_nettype none
module ufx_back
    import ufx_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire q_status_t  q,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_stall,
    output item_t           out_item
);

    logic        cur_valid_reg;
    item_t [3:0] cur_items_reg;
    logic [2:0]  cur_cnt_reg;
    logic [1:0]  cur_idx_reg;
    logic        out_valid_reg;
    item_t       out_item_reg;
    logic        load;
    item_t       sel;

    assign load = (cur_valid_reg || !q.empty) && (!out_valid_reg || !out_stall);
    assign pop  = load && !cur_valid_reg;
    assign sel  = cur_valid_reg ? cur_items_reg[cur_idx_reg] : q.head.items[0];

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_ff @(posedge clk)
    begin
        if (load) out_item_reg <= sel;
        if (pop) cur_items_reg <= q.head.items;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cur_valid_reg <= 1'b0;
            cur_cnt_reg   <= 3'd0;
            cur_idx_reg   <= 2'd0;
        end
        else
        begin
            if (load) out_valid_reg <= 1'b1;
            else if (!out_stall) out_valid_reg <= 1'b0;

            if (load && cur_valid_reg)
            begin
                cur_idx_reg <= cur_idx_reg + 2'd1;
                if ({1'b0, cur_idx_reg} + 3'd1 == cur_cnt_reg) cur_valid_reg <= 1'b0;
            end
            else if (pop)
            begin
                cur_cnt_reg   <= q.head.cnt;
                cur_idx_reg   <= 2'd1;
                cur_valid_reg <= (q.head.cnt > 3'd1);
            end
        end
    end

endmodule
`default_nettype wire

// File: design/url_form_field_extractor_top.sv
// URL form field extractor: finds a tag in a query byte stream and emits its decoded value.
//
// Input channel: one buffer byte per word (data_byte, end_of_buffer), taken when
// in_valid is high and in_stall is low. Output channel: one result word per
// accepted handshake (value_byte, is_done, found, last_of_run); last_of_run marks
// the final word caused by one input word, and the word that closes a buffer
// carries is_done with found.
// Each input word causes zero to four result words. The front end takes one input
// word per cycle while the queue is not full and packs its results into one bundle
// of a four-entry queue; the back end sends one result word per cycle from an output
// register while out_stall is low. Sustained rate is one input word per cycle while
// each word yields at most one result and the output is not stalled; a word with
// several results holds the back end until all are sent. in_stall rises only when
// the queue is full, so a stalled output lets up to five result-producing words
// (and any number of silent ones) in before the input stalls. Reset returns the
// search state to the start of a buffer and the registers to tag length 1, empty
// tag and a value limit of 1024 bytes. The user writes configuration through
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce this.
`default_nettype none
module url_form_field_extractor_top
    import ufx_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  end_of_buffer,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [7:0]                 value_byte,
    output logic                       is_done,
    output logic                       found,
    output logic                       last_of_run,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    q_push_t   push;
    q_status_t qs;
    logic      pop;
    logic      in_accept;
    item_t     item;

    ufx_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .data_byte     (data_byte),
        .end_of_buffer (end_of_buffer),
        .q_full        (qs.full),
        .in_accept     (in_accept),
        .push          (push),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    ufx_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .status (qs)
    );

    ufx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q         (qs),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (item)
    );

    assign in_stall    = qs.full;
    assign value_byte  = item.value;
    assign is_done     = item.is_done;
    assign found       = item.found;
    assign last_of_run = item.last;

    // a done word always closes its run
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_done |-> last_of_run)
        else $error("done word without last_of_run");

    // value words never report found, done words carry a zero byte
    a_done_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_done |-> !found)
        else $error("found set on a value word");

    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_done |-> value_byte == 8'd0)
        else $error("done word with nonzero byte");

    // an input word that produces results must fit in the queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> in_accept && !qs.full)
        else $error("queue push while full");

endmodule
`default_nettype wire
